@@ hdl/mcsg_pkg.sv @@
// Package for the multichannel sine test generator.
// Holds the default sizes, the register index codes and the quarter-wave sine builder.
// No dependencies.
`default_nettype none

package mcsg_pkg;

  localparam int unsigned TABLE_ADDR_BITS = 10;
  localparam int unsigned MAX_CHANNELS    = 4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned INDEX_W     = 16;
  localparam int unsigned OFFSET_W    = 16;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned CHAN_W      = 2;
  localparam int unsigned CHANS_W     = 3;
  localparam int unsigned NUM_OFFSETS = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_CH0   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_CH1   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_CH2   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_CH3   = 3'd6;

  localparam logic [INDEX_W-1:0] CHUNK_LENGTH_RESET = 16'd256;
  localparam logic [CHANS_W-1:0] CHANNELS_RESET     = 3'd1;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // Magnitude of sin(pi*m/(N/2)) in Q15, from a Q30 Taylor series up to x^11.
  function automatic logic [SAMPLE_W-1:0] quarter_sine(int unsigned m, int unsigned addr_bits);
    logic [63:0]        pi46;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    pi46 = PI_Q60 >> 14;
    x    = (pi46 * 64'(m) + (64'd1 << (addr_bits + 14))) >> (addr_bits + 15);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    return SAMPLE_W'(64'(sum) >> 15);
  endfunction

endpackage

`default_nettype wire

@@ hdl/mcsg_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module mcsg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/multichannel_sine_test_generator.sv @@
// Top level of the multichannel sine test generator.
// Depends on mcsg_pkg and mcsg_ram (the sine table memory).
`default_nettype none

// After reset the block loads its sine table into an on-chip memory, one entry per
// cycle, for all 2**TableAddrBits entries (1024 at the default size); no tick is taken
// during that load, configuration writes are. Each tick then produces one sample per
// channel in use, channel 0 first; the single read port of the sine memory serves one
// channel per cycle unless the output is stalled. Results leave through an output
// register, so a stalled consumer does not lose a sample. Write configuration only
// while the block is idle.
module multichannel_sine_test_generator
  import mcsg_pkg::*;
#(
  parameter int unsigned TableAddrBits = TABLE_ADDR_BITS,
  parameter int unsigned MaxChannels   = MAX_CHANNELS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   restart_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic signed [SAMPLE_W-1:0]  sample_o,
  output logic        [CHAN_W-1:0]    channel_o,
  output logic        [INDEX_W-1:0]   sample_index_o,
  output logic                        last_of_tick_o,
  output logic                        last_of_chunk_o
);

  localparam int unsigned TableDepth = 1 << TableAddrBits;
  localparam int unsigned Quarter    = 1 << (TableAddrBits - 2);

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  typedef logic [SAMPLE_W-1:0] qtab_t [Quarter+1];

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [INDEX_W-1:0] idx;
    logic               last_tick;
    logic               last_chunk;
  } side_t;

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int m = 0; m <= int'(Quarter); m++) begin
      t[m] = quarter_sine(m, TableAddrBits);
    end
    return t;
  endfunction

  localparam qtab_t QTab = build_qtab();

  // configuration
  logic [PHASE_W-1:0]  step_q;
  logic [CHANS_W-1:0]  chans_q;
  logic [INDEX_W-1:0]  chunk_q;
  logic [OFFSET_W-1:0] offset_q [NUM_OFFSETS];

  // control
  logic [1:0]               state_q;
  logic [TableAddrBits-1:0] fill_q;
  logic [CHAN_W-1:0]        chan_q;
  logic [CHAN_W-1:0]        last_chan_q;
  logic [INDEX_W-1:0]       index_q;
  logic [PHASE_W-1:0]       phase_q;
  logic [INDEX_W-1:0]       tick_idx_q;
  logic [PHASE_W-1:0]       tick_phase_q;
  logic                     tick_last_q;
  logic                     r_valid_q;
  side_t                    r_side_q;
  logic                     out_valid_q;
  side_t                    out_side_q;
  logic [SAMPLE_W-1:0]      out_sample_q;

  logic                     in_accept;
  logic                     s2_free;
  logic                     s1_move;
  logic                     issue;
  logic [INDEX_W-1:0]       len_m1;
  logic [CHAN_W-1:0]        last_chan_d;
  logic [INDEX_W-1:0]       idx0;
  logic [PHASE_W-1:0]       phase0;
  logic                     last0;
  logic [PHASE_W-1:0]       phase_sum;
  logic [TableAddrBits-1:0] raddr;
  logic [SAMPLE_W-1:0]      rdata;
  logic [1:0]               fill_quad;
  logic [TableAddrBits-2:0] fill_m;
  logic [SAMPLE_W-1:0]      fill_mag;
  logic [SAMPLE_W-1:0]      fill_value;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign s2_free     = !out_valid_q || out_ready_i;
  assign s1_move     = r_valid_q && s2_free;
  assign issue       = (state_q == ST_RUN) && (!r_valid_q || s2_free);

  always_comb begin
    len_m1 = (chunk_q == '0) ? '0 : chunk_q - 16'd1;
    if (chans_q == '0) begin
      last_chan_d = '0;
    end else if (chans_q > CHANS_W'(MaxChannels)) begin
      last_chan_d = CHAN_W'(MaxChannels - 1);
    end else begin
      last_chan_d = CHAN_W'(chans_q - 3'd1);
    end
    if (restart_i || (index_q > len_m1)) begin
      idx0   = '0;
      phase0 = '0;
    end else begin
      idx0   = index_q;
      phase0 = phase_q;
    end
    last0 = (idx0 == len_m1);
  end

  assign phase_sum = tick_phase_q + {offset_q[chan_q], 16'h0000};
  assign raddr     = phase_sum[PHASE_W-1 -: TableAddrBits];

  always_comb begin
    fill_quad = fill_q[TableAddrBits-1 -: 2];
    if (fill_quad[0]) begin
      fill_m = (TableAddrBits-1)'(Quarter) - {1'b0, fill_q[TableAddrBits-3:0]};
    end else begin
      fill_m = {1'b0, fill_q[TableAddrBits-3:0]};
    end
    fill_mag = QTab[fill_m];
    if (!fill_quad[1]) begin
      fill_value = (fill_mag > 16'h7FFF) ? 16'h7FFF : fill_mag;
    end else begin
      fill_value = 16'h0000 - fill_mag;
    end
  end

  mcsg_ram #(
    .Width(SAMPLE_W),
    .Depth(TableDepth)
  ) u_sine_ram (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_FILL),
    .waddr_i(fill_q),
    .wdata_i(fill_value),
    .re_i   (issue),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      chans_q  <= CHANNELS_RESET;
      chunk_q  <= CHUNK_LENGTH_RESET;
      offset_q <= '{default: '0};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PHASE_STEP:   step_q      <= cfg_data_i;
        REG_CHANNELS:     chans_q     <= cfg_data_i[CHANS_W-1:0];
        REG_CHUNK_LENGTH: chunk_q     <= cfg_data_i[INDEX_W-1:0];
        REG_OFFSET_CH0:   offset_q[0] <= cfg_data_i[OFFSET_W-1:0];
        REG_OFFSET_CH1:   offset_q[1] <= cfg_data_i[OFFSET_W-1:0];
        REG_OFFSET_CH2:   offset_q[2] <= cfg_data_i[OFFSET_W-1:0];
        REG_OFFSET_CH3:   offset_q[3] <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      fill_q      <= '0;
      chan_q      <= '0;
      last_chan_q <= '0;
      index_q     <= '0;
      phase_q     <= '0;
      r_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_FILL: begin
          fill_q <= fill_q + 1'b1;
          if (fill_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            state_q     <= ST_RUN;
            chan_q      <= '0;
            last_chan_q <= last_chan_d;
            if (last0) begin
              index_q <= '0;
              phase_q <= '0;
            end else begin
              index_q <= idx0 + 16'd1;
              phase_q <= phase0 + step_q;
            end
          end
        end
        ST_RUN: begin
          if (issue) begin
            chan_q <= chan_q + 1'b1;
            if (chan_q == last_chan_q) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (issue) begin
        r_valid_q <= 1'b1;
      end else if (s1_move) begin
        r_valid_q <= 1'b0;
      end

      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tick_idx_q   <= idx0;
      tick_phase_q <= phase0;
      tick_last_q  <= last0;
    end
    if (issue) begin
      r_side_q <= '{chan: chan_q, idx: tick_idx_q, last_tick: (chan_q == last_chan_q),
                    last_chunk: tick_last_q};
    end
    if (s1_move) begin
      out_side_q   <= r_side_q;
      out_sample_q <= rdata;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_o        = signed'(out_sample_q);
  assign channel_o       = out_side_q.chan;
  assign sample_index_o  = out_side_q.idx;
  assign last_of_tick_o  = out_side_q.last_tick;
  assign last_of_chunk_o = out_side_q.last_chunk;

endmodule

`default_nettype wire
